### rtl/core/rvss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvss_pkg
// Shared types, constants and helpers for the rv32 subset instruction step.
// ----------------------------------------------------------------------------
package rvss_pkg;

    localparam int XLEN      = 32;
    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int NUM_REGS  = 32;
    localparam int RF_AW     = $clog2(NUM_REGS);

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_ADDI = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_LOAD
    } rvss_state_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_HALTED      = 3'd1,
        STAT_FETCH_ERR   = 3'd2,
        STAT_LOAD_ERR    = 3'd3,
        STAT_STORE_ERR   = 3'd4,
        STAT_UNKNOWN_OPC = 3'd5
    } rvss_status_t;

    typedef struct packed {
        rvss_status_t      status;
        logic [XLEN-1:0]   pc_after;
        logic              is_halted;
        logic              reg_written;
        logic [RF_AW-1:0]  reg_index;
        logic [XLEN-1:0]   reg_value;
    } rvss_result_t;

    // word aligned and inside the word memory
    function automatic logic addr_ok(input logic [XLEN-1:0] addr);
        return (addr[1:0] == 2'b00) && ((addr >> 2) < XLEN'(MEM_WORDS));
    endfunction

endpackage

### rtl/core/rv32_subset_instruction_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_subset_instruction_step
// Tiny RV32 core stepping LW, SW, ADDI, LUI, JAL and JALR one item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries mode, word_index and
//   word_data. Mode 0 writes one memory word, mode 1 executes one
//   instruction at pc. Every accepted item gives one result on the output
//   channel (result_valid / result_stall).
//   Steps: a memory write, an execute while halted and a fetch error finish
//   in the idle state that accepts them. Other instructions step through
//   fetch read, register file read and execute; LW adds a data memory read.
//   The steps come from the registered reads of word memory and register file.
//   Results pass the pending, then the output register to result_valid.
//   A pending result plus the output register let the next item be taken
//   while a result waits; with both full, item_stall rises.
//   Reset: pc = 0, not halted, all registers read zero, memory undefined.
//   Writing cfg_write_data (start address) reloads pc, clears halted and
//   all registers; memory is kept. Write it only while idle.
// ----------------------------------------------------------------------------
module rv32_subset_instruction_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [9:0]  word_index,
    input  logic [31:0] word_data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [31:0] pc_after,
    output logic        is_halted,
    output logic        reg_written,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value
);

    import rvss_pkg::*;

    rvss_state_t       state_reg, state_next;
    logic [XLEN-1:0]   pc_reg, pc_next;
    logic              halted_reg, halted_next;
    logic [XLEN-1:0]   inst_reg, inst_next;
    logic [NUM_REGS-1:0] rf_valid_reg, rf_valid_next;

    rvss_result_t      pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    rvss_result_t      out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [XLEN-1:0]   mem_wdata, mem_rdata;

    logic              rf_we;
    logic [RF_AW-1:0]  rf_waddr, rf_raddr1, rf_raddr2;
    logic [XLEN-1:0]   rf_wdata, rf_rdata1, rf_rdata2;

    logic              item_accept, out_load, pend_free, fin, dow;
    rvss_result_t      res;
    logic [XLEN-1:0]   rs1_val, rs2_val, imm_i, imm_s, imm_j, imm_u;
    logic [XLEN-1:0]   ad_load, ad_store, pc_plus4, wval;
    logic [6:0]        opc;
    logic [2:0]        f3;
    logic [RF_AW-1:0]  rd;

    rvss_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_word_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // register file kept as two mirrored banks for the two read ports
    rvss_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_bank_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr1),
        .rdata (rf_rdata1)
    );

    rvss_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_bank_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr2),
        .rdata (rf_rdata2)
    );

    assign out_load    = pend_valid_reg && (!out_valid_reg || !result_stall);
    assign pend_free   = !pend_valid_reg || out_load;
    assign item_stall  = !((state_reg == ST_IDLE) && pend_free);
    assign item_accept = item_valid && !item_stall;

    // instruction fields and operands during execute
    assign opc      = inst_reg[6:0];
    assign rd       = inst_reg[11:7];
    assign f3       = inst_reg[14:12];
    assign rs1_val  = rf_valid_reg[inst_reg[19:15]] ? rf_rdata1 : '0;
    assign rs2_val  = rf_valid_reg[inst_reg[24:20]] ? rf_rdata2 : '0;
    assign imm_i    = {{20{inst_reg[31]}}, inst_reg[31:20]};
    assign imm_s    = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign imm_j    = {{11{inst_reg[31]}}, inst_reg[31], inst_reg[19:12],
                       inst_reg[20], inst_reg[30:21], 1'b0};
    assign imm_u    = {inst_reg[31:12], 12'b0};
    assign ad_load  = rs1_val + imm_i;
    assign ad_store = rs1_val + imm_s;
    assign pc_plus4 = pc_reg + XLEN'(4);

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        halted_next = halted_reg;
        inst_next   = inst_reg;
        mem_we      = 1'b0;
        mem_waddr   = MEM_AW'(word_index);
        mem_wdata   = word_data;
        mem_raddr   = pc_reg[MEM_AW+1:2];
        rf_raddr1   = mem_rdata[19:15];
        rf_raddr2   = mem_rdata[24:20];
        fin         = 1'b0;
        dow         = 1'b0;
        wval        = '0;
        res         = '0;
        res.status  = STAT_OK;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (!mode)
                    begin
                        mem_we = (XLEN'(word_index) < XLEN'(MEM_WORDS));
                        fin    = 1'b1;
                    end
                    else if (halted_reg)
                    begin
                        res.status = STAT_HALTED;
                        fin        = 1'b1;
                    end
                    else if (!addr_ok(pc_reg))
                    begin
                        halted_next = 1'b1;
                        res.status  = STAT_FETCH_ERR;
                        fin         = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                inst_next  = mem_rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                fin     = 1'b1;
                pc_next = pc_plus4;
                case (opc)
                    OPC_LOAD:
                    begin
                        if (f3 == F3_WORD)
                        begin
                            if (!addr_ok(ad_load))
                            begin
                                halted_next = 1'b1;
                                res.status  = STAT_LOAD_ERR;
                            end
                            else
                            begin
                                mem_raddr = ad_load[MEM_AW+1:2];
                                fin       = 1'b0;
                                pc_next   = pc_reg;
                            end
                        end
                    end
                    OPC_OP_IMM:
                    begin
                        if (f3 == F3_ADDI)
                        begin
                            dow  = 1'b1;
                            wval = ad_load;
                        end
                    end
                    OPC_STORE:
                    begin
                        if (f3 == F3_WORD)
                        begin
                            if (!addr_ok(ad_store))
                            begin
                                halted_next = 1'b1;
                                res.status  = STAT_STORE_ERR;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ad_store[MEM_AW+1:2];
                                mem_wdata = rs2_val;
                            end
                        end
                    end
                    OPC_LUI:
                    begin
                        dow  = 1'b1;
                        wval = imm_u;
                    end
                    OPC_JALR:
                    begin
                        dow     = 1'b1;
                        wval    = pc_plus4;
                        pc_next = {ad_load[XLEN-1:1], 1'b0};
                    end
                    OPC_JAL:
                    begin
                        dow     = 1'b1;
                        wval    = pc_plus4;
                        pc_next = pc_reg + imm_j;
                    end
                    default:
                    begin
                        halted_next = 1'b1;
                        res.status  = STAT_UNKNOWN_OPC;
                    end
                endcase
                state_next = fin ? ST_IDLE : ST_LOAD;
            end
            ST_LOAD:
            begin
                dow        = 1'b1;
                wval       = mem_rdata;
                pc_next    = pc_plus4;
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rf_we    = dow && (rd != '0);
        rf_waddr = rd;
        rf_wdata = wval;

        res.pc_after    = pc_next;
        res.is_halted   = halted_next;
        res.reg_written = rf_we;
        res.reg_index   = rf_we ? rd : '0;
        res.reg_value   = rf_we ? wval : '0;
    end

    // pending result and output register
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        if (out_load)
        begin
            out_next        = pend_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (fin)
        begin
            pend_next       = res;
            pend_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (cfg_write_en)
        begin
            rf_valid_next = '0;
        end
        else if (rf_we)
        begin
            rf_valid_next[rf_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            halted_reg     <= 1'b0;
            rf_valid_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rf_valid_reg   <= rf_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                pc_reg     <= cfg_write_data;
                halted_reg <= 1'b0;
            end
            else
            begin
                pc_reg     <= pc_next;
                halted_reg <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        inst_reg <= inst_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign pc_after     = out_reg.pc_after;
    assign is_halted    = out_reg.is_halted;
    assign reg_written  = out_reg.reg_written;
    assign reg_index    = out_reg.reg_index;
    assign reg_value    = out_reg.reg_value;

endmodule

### rtl/core/rvss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rvss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
